/* src/rmfb_pkg.sv */
// shared types and codes for the rotated monochrome frame buffer
`timescale 1ns / 1ps

package rmfb_pkg;

  typedef enum logic [1:0] {
    CMD_PIXEL = 2'd0,
    CMD_FILL  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_INDEX,
    ST_FETCH,
    ST_FILL,
    ST_FINISH
  } state_t;

  // controller to datapath step commands
  typedef struct packed {
    logic load;
    logic map;
    logic index;
    logic fetch;
    logic fill_wr;
    logic finish;
  } dp_ctl_t;

  localparam logic [7:0] BYTE_ONES = 8'hFF;
  localparam int unsigned BIT_LAST = 7;

endpackage

/* src/rmfb_ctrl.sv */
// controller state machine for the rotated monochrome frame buffer
`timescale 1ns / 1ps

module rmfb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_command,
  input  logic              fill_last,
  output logic              busy,
  output logic              out_valid,
  output rmfb_pkg::dp_ctl_t ctl
);

  rmfb_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmfb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    ctl           = '0;
    unique case (state_r)
      rmfb_pkg::ST_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          unique case (rmfb_pkg::cmd_t'(in_command))
            rmfb_pkg::CMD_PIXEL: state_nxt = rmfb_pkg::ST_MAP;
            rmfb_pkg::CMD_READ:  state_nxt = rmfb_pkg::ST_INDEX;
            rmfb_pkg::CMD_FILL:  state_nxt = rmfb_pkg::ST_FILL;
            default:             state_nxt = rmfb_pkg::ST_FINISH;
          endcase
        end
      end
      rmfb_pkg::ST_MAP: begin
        ctl.map   = 1'b1;
        state_nxt = rmfb_pkg::ST_INDEX;
      end
      rmfb_pkg::ST_INDEX: begin
        ctl.index = 1'b1;
        state_nxt = rmfb_pkg::ST_FETCH;
      end
      rmfb_pkg::ST_FETCH: begin
        ctl.fetch = 1'b1;
        state_nxt = rmfb_pkg::ST_FINISH;
      end
      rmfb_pkg::ST_FILL: begin
        ctl.fill_wr = 1'b1;
        if (fill_last) begin
          state_nxt = rmfb_pkg::ST_FINISH;
        end
      end
      rmfb_pkg::ST_FINISH: begin
        ctl.finish    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = rmfb_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rmfb_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != rmfb_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_fetch_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmfb_pkg::ST_FETCH) |=> ##1 out_valid)
    else $error("memory fetch not followed by a result");

endmodule

/* src/rmfb_dp.sv */
// datapath and frame memory for the rotated monochrome frame buffer
`timescale 1ns / 1ps

module rmfb_dp #(
  parameter int unsigned PANEL_WIDTH  = 200,
  parameter int unsigned PANEL_HEIGHT = 200
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rmfb_pkg::dp_ctl_t ctl,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata,
  input  logic [1:0]        in_command,
  input  logic signed [15:0] in_pixel_x,
  input  logic signed [15:0] in_pixel_y,
  input  logic [15:0]       in_colour,
  input  logic [7:0]        in_read_column,
  input  logic [9:0]        in_read_row,
  output logic              fill_last,
  output logic [7:0]        out_read_data,
  output logic              out_pixel_drawn
);

  localparam int unsigned ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
  localparam int unsigned STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
  localparam int unsigned ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int unsigned RB_W        = $clog2(ROW_BYTES + 1);
  localparam int unsigned IDX_W       = 10 + RB_W + 1;
  localparam int unsigned PX_W        = $clog2(PANEL_WIDTH);
  localparam int unsigned PY_W        = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
  localparam logic signed [16:0] LIM_W = 17'(PANEL_WIDTH);
  localparam logic signed [16:0] LIM_H = 17'(PANEL_HEIGHT);
  localparam logic [PX_W-1:0] PX_MAX   = PX_W'(PANEL_WIDTH - 1);
  localparam logic [PY_W-1:0] PY_MAX   = PY_W'(PANEL_HEIGHT - 1);

  logic [7:0] mem [STORE_BYTES];

  logic [1:0]         rotation_r;
  rmfb_pkg::cmd_t     cmd_r;
  logic signed [15:0] x_r, y_r;
  logic               colour_nz_r;
  logic [7:0]         col_r;
  logic [9:0]         row_r;
  logic               clip_ok_r;
  logic [PX_W-1:0]    px_r, px_nxt;
  logic [PY_W-1:0]    py_r, py_nxt;
  logic [IDX_W-1:0]   idx_r;
  logic               hit_r;
  logic [7:0]         rd_data_r;
  logic [ADDR_W-1:0]  fill_addr_r;
  logic [7:0]         read_data_r;
  logic               drawn_r;

  logic signed [16:0] x_ext, y_ext, lim_x, lim_y;
  logic               clip_ok_nxt;
  logic [9:0]         mul_a;
  logic [7:0]         add_b;
  logic [IDX_W-1:0]   idx_nxt;
  logic [7:0]         mask;
  logic [7:0]         wr_byte;
  logic               pix_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotation_r <= 2'd0;
    end else if (cfg_we) begin
      rotation_r <= cfg_wdata;
    end
  end

  // clip against the rotated area
  assign x_ext = $signed({x_r[15], x_r});
  assign y_ext = $signed({y_r[15], y_r});
  assign lim_x = rotation_r[0] ? LIM_H : LIM_W;
  assign lim_y = rotation_r[0] ? LIM_W : LIM_H;
  assign clip_ok_nxt = !x_ext[16] && !y_ext[16] && (x_ext < lim_x) && (y_ext < lim_y);

  // quarter-turn mapping, only meaningful when the point is inside
  always_comb begin
    case (rotation_r)
      2'd1: begin
        px_nxt = PX_MAX - y_r[PX_W-1:0];
        py_nxt = x_r[PY_W-1:0];
      end
      2'd2: begin
        px_nxt = PX_MAX - x_r[PX_W-1:0];
        py_nxt = PY_MAX - y_r[PY_W-1:0];
      end
      2'd3: begin
        px_nxt = y_r[PX_W-1:0];
        py_nxt = PY_MAX - x_r[PY_W-1:0];
      end
      default: begin
        px_nxt = x_r[PX_W-1:0];
        py_nxt = y_r[PY_W-1:0];
      end
    endcase
  end

  // byte index: row times row pitch plus byte column
  always_comb begin
    if (cmd_r == rmfb_pkg::CMD_READ) begin
      mul_a = row_r;
      add_b = col_r;
    end else begin
      mul_a = 10'(py_r);
      add_b = 8'(px_r >> 3);
    end
  end
  assign idx_nxt = IDX_W'(mul_a) * IDX_W'(ROW_BYTES) + IDX_W'(add_b);

  assign mask    = 8'h80 >> (px_r & PX_W'(rmfb_pkg::BIT_LAST));
  assign wr_byte = colour_nz_r ? (rd_data_r & ~mask) : (rd_data_r | mask);
  assign pix_wr  = ctl.finish && (cmd_r == rmfb_pkg::CMD_PIXEL) && hit_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r       <= rmfb_pkg::cmd_t'(in_command);
      x_r         <= in_pixel_x;
      y_r         <= in_pixel_y;
      colour_nz_r <= (in_colour != 16'd0);
      col_r       <= in_read_column;
      row_r       <= in_read_row;
    end
    if (ctl.map) begin
      clip_ok_r <= clip_ok_nxt;
      px_r      <= px_nxt;
      py_r      <= py_nxt;
    end
    if (ctl.index) begin
      idx_r <= idx_nxt;
    end
    if (ctl.fetch) begin
      hit_r <= (cmd_r == rmfb_pkg::CMD_READ) ? (idx_r < IDX_W'(STORE_BYTES)) : clip_ok_r;
    end
    if (ctl.finish) begin
      read_data_r <= (cmd_r != rmfb_pkg::CMD_READ) ? 8'd0 :
                     (hit_r ? ~rd_data_r : rmfb_pkg::BYTE_ONES);
      drawn_r     <= (cmd_r == rmfb_pkg::CMD_PIXEL) && hit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      fill_addr_r <= '0;
    end else if (ctl.fill_wr) begin
      fill_addr_r <= fill_addr_r + ADDR_W'(1);
    end
  end
  assign fill_last = (fill_addr_r == ADDR_W'(STORE_BYTES - 1));

  // single write port, single registered read port
  always_ff @(posedge clk) begin
    if (ctl.fill_wr) begin
      mem[fill_addr_r] <= colour_nz_r ? 8'd0 : rmfb_pkg::BYTE_ONES;
    end else if (pix_wr) begin
      mem[idx_r[ADDR_W-1:0]] <= wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fetch) begin
      rd_data_r <= mem[idx_r[ADDR_W-1:0]];
    end
  end

  assign out_read_data   = read_data_r;
  assign out_pixel_drawn = drawn_r;

endmodule

/* src/rotated_mono_framebuffer_unit.sv */
// top level of the rotated monochrome frame buffer
`timescale 1ns / 1ps

// channel   | ports                                         | handshake
// ----------+-----------------------------------------------+--------------------------
// input     | in_command, in_pixel_x/y, in_colour,          | start high, busy low
//           | in_read_column, in_read_row                   |
// result    | out_read_data, out_pixel_drawn                | out_valid, one cycle
// config    | cfg_wdata (rotation)                          | cfg_we, no wait
//
// a pixel write runs map, index multiply, memory fetch and read-modify-write, then the
// result register; a byte read skips the map step, an unused command all but finish
// a fill sweeps the memory one byte per cycle, ROW_BYTES*PANEL_HEIGHT bytes in all
// busy drops in the cycle the result is shown, so the next item can enter then
// reset is synchronous and clears the controller and the rotation register only
// the frame memory is undefined until filled or written; the receiver cannot stall

module rotated_mono_framebuffer_unit #(
  parameter int unsigned PANEL_WIDTH  = 200,
  parameter int unsigned PANEL_HEIGHT = 200
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_command,
  input  logic signed [15:0] in_pixel_x,
  input  logic signed [15:0] in_pixel_y,
  input  logic [15:0]       in_colour,
  input  logic [7:0]        in_read_column,
  input  logic [9:0]        in_read_row,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata,
  output logic              out_valid,
  output logic [7:0]        out_read_data,
  output logic              out_pixel_drawn
);

  rmfb_pkg::dp_ctl_t ctl;
  logic              fill_last;

  // sequencer: one item at a time
  rmfb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .fill_last  (fill_last),
    .busy       (busy),
    .out_valid  (out_valid),
    .ctl        (ctl)
  );

  // coordinate mapping, index arithmetic and the frame memory
  rmfb_dp #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_command      (in_command),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .in_colour       (in_colour),
    .in_read_column  (in_read_column),
    .in_read_row     (in_read_row),
    .fill_last       (fill_last),
    .out_read_data   (out_read_data),
    .out_pixel_drawn (out_pixel_drawn)
  );

endmodule
